>>> src/klc_pkg.sv
package klc_pkg;

  // request kinds carried on in_tuser
  localparam logic [2:0] REQ_UPSERT  = 3'd0;
  localparam logic [2:0] REQ_RM_IDX  = 3'd1;
  localparam logic [2:0] REQ_RM_KEY  = 3'd2;
  localparam logic [2:0] REQ_ADVANCE = 3'd3;
  localparam logic [2:0] REQ_SHOW    = 3'd4;
  localparam logic [2:0] REQ_LOOKUP  = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  localparam int KEY_W  = 32;
  localparam int PLD_W  = 32;
  localparam int ENT_W  = KEY_W + PLD_W;

  // one finished result, handed from the sequencer to the output register
  typedef struct packed {
    logic [3:0]       found_index;
    logic [PLD_W-1:0] cursor_payload;
    logic [KEY_W-1:0] cursor_key;
    logic [4:0]       entry_total;
    logic [3:0]       cursor_index;
    logic             has_entry;
    logic [1:0]       status;
  } res_t;

endpackage

>>> src/keyed_list_with_cursor_unit.sv
// Ordered list of up to DEPTH entries (32-bit key, 32-bit payload handle) with a
// cursor. Each transaction on the in_ side is one request (upsert, remove at
// index, remove by key, advance, show, look up) and gives exactly one result
// transaction on the out_ side. Requests are handled one at a time: in_tready
// stays low after acceptance until the result has moved into the output
// register, so no new request is taken while one is in flight. The key search
// (only for upsert, remove by key and look up) visits entries up to the entry
// count, and a remove shifts the later entries down one at a time. While the
// output register still holds a result that out_tready has not taken, the
// sequencer waits in its last step and in_tready stays low. The time taken is
// set by the registered-read entry memory: each search step and each shift step
// is a registered read followed by a compare or a write. Entries are never
// cleared; there is no start-up pass.
module keyed_list_with_cursor_unit #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // entry_key[31:0], entry_payload[63:32],
                                  // entry_index[67:64], zero pad[71:68]
  input  logic [2:0]  in_tuser,   // req_type[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata   // status[1:0], has_entry[2], cursor_index[6:3],
                                  // entry_total[11:7], cursor_key[43:12],
                                  // cursor_payload[75:44], found_index[79:76]
);
  import klc_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // memory port between sequencer and entry store
  logic             mem_we;
  logic [IW-1:0]    mem_waddr;
  logic [ENT_W-1:0] mem_wdata;
  logic [IW-1:0]    mem_raddr;
  logic [ENT_W-1:0] mem_rdata;

  // finished result from the sequencer
  res_t res;
  logic res_valid;
  logic res_ready;

  // output register, lets the result wait without holding the sequencer's state
  res_t out_res_r;
  logic out_tvalid_r;

  klc_mem #(.DEPTH(DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  klc_seq #(.DEPTH(DEPTH)) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .req_type    (in_tuser),
    .req_key     (in_tdata[31:0]),
    .req_payload (in_tdata[63:32]),
    .req_index   (in_tdata[67:64]),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata),
    .res         (res),
    .res_valid   (res_valid),
    .res_ready   (res_ready)
  );

  // register is free when empty or being drained this cycle
  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  // struct is declared lowest field last, so it packs straight onto tdata
  assign out_tdata  = out_res_r;

endmodule

>>> src/klc_mem.sv
module klc_mem #(
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [klc_pkg::ENT_W-1:0] wdata,
  input  logic [AW-1:0]         raddr,
  output logic [klc_pkg::ENT_W-1:0] rdata
);
  import klc_pkg::*;

  // entry layout: key in the upper half, payload in the lower half
  logic [ENT_W-1:0] mem [DEPTH];
  logic [ENT_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/klc_seq.sv
module klc_seq #(
  parameter int DEPTH = 16,
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                req_type,
  input  logic [klc_pkg::KEY_W-1:0] req_key,
  input  logic [klc_pkg::PLD_W-1:0] req_payload,
  input  logic [3:0]                req_index,
  output logic                      mem_we,
  output logic [IW-1:0]             mem_waddr,
  output logic [klc_pkg::ENT_W-1:0] mem_wdata,
  output logic [IW-1:0]             mem_raddr,
  input  logic [klc_pkg::ENT_W-1:0] mem_rdata,
  output klc_pkg::res_t             res,
  output logic                      res_valid,
  input  logic                      res_ready
);
  import klc_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SRD   = 9'b000000010,
    S_SCMP  = 9'b000000100,
    S_APPLY = 9'b000001000,
    S_CRD   = 9'b000010000,
    S_CWR   = 9'b000100000,
    S_CLAMP = 9'b001000000,
    S_ORD   = 9'b010000000,
    S_OCAP  = 9'b100000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [2:0]       kind_r, kind_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [PLD_W-1:0] pld_r, pld_nxt;
  logic [3:0]       index_r, index_nxt;
  logic [IW-1:0]    scan_r, scan_nxt;
  logic [IW-1:0]    pos_r, pos_nxt;
  logic             hit_r, hit_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [IW-1:0]    cursor_r, cursor_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [IW-1:0]    found_r, found_nxt;

  logic             key_eq;
  logic [CW-1:0]    scan_inc;
  logic [CW-1:0]    cursor_inc;
  logic [IW+3:0]    idx_w;
  logic [IW-1:0]    idx_iw;
  logic [CW+3:0]    idx_c;
  logic [CW+3:0]    cnt_c;
  logic [IW-1:0]    drop_pos;
  logic             do_drop;
  logic [IW+3:0]    cur_w;
  logic [IW+3:0]    fnd_w;
  logic [CW+4:0]    cnt_w;
  logic             has;

  // the one shared comparator: stored key against the request key
  assign key_eq     = (mem_rdata[ENT_W-1:PLD_W] == key_r);
  assign scan_inc   = CW'(scan_r) + CW'(1);
  assign cursor_inc = CW'(cursor_r) + CW'(1);
  assign idx_w      = {{IW{1'b0}}, index_r};
  assign idx_iw     = idx_w[IW-1:0];
  assign idx_c      = {{CW{1'b0}}, index_r};
  assign cnt_c      = {4'b0000, count_r};
  assign drop_pos   = (kind_r == REQ_RM_IDX) ? idx_iw : pos_r;
  assign in_ready   = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    kind_nxt   = kind_r;
    key_nxt    = key_r;
    pld_nxt    = pld_r;
    index_nxt  = index_r;
    scan_nxt   = scan_r;
    pos_nxt    = pos_r;
    hit_nxt    = hit_r;
    count_nxt  = count_r;
    cursor_nxt = cursor_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    mem_we     = 1'b0;
    mem_waddr  = scan_r;
    mem_wdata  = {key_r, pld_r};
    mem_raddr  = scan_r;
    res_valid  = 1'b0;
    do_drop    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt   = req_type;
          key_nxt    = req_key;
          pld_nxt    = req_payload;
          index_nxt  = req_index;
          scan_nxt   = '0;
          hit_nxt    = 1'b0;
          status_nxt = ST_OK;
          found_nxt  = '0;
          if ((req_type == REQ_UPSERT || req_type == REQ_RM_KEY ||
               req_type == REQ_LOOKUP) && count_r != '0) begin
            state_nxt = S_SRD;
          end else begin
            state_nxt = S_APPLY;
          end
        end
      end
      S_SRD: begin
        state_nxt = S_SCMP;
      end
      S_SCMP: begin
        if (key_eq) begin
          hit_nxt   = 1'b1;
          pos_nxt   = scan_r;
          state_nxt = S_APPLY;
        end else if (scan_inc == count_r) begin
          state_nxt = S_APPLY;
        end else begin
          scan_nxt  = scan_r + 1'b1;
          state_nxt = S_SRD;
        end
      end
      S_APPLY: begin
        state_nxt = S_CLAMP;
        if (kind_r == REQ_UPSERT) begin
          if (hit_r) begin
            mem_we     = 1'b1;
            mem_waddr  = pos_r;
            cursor_nxt = pos_r;
          end else if (count_r == CW'(DEPTH)) begin
            status_nxt = ST_FULL;
          end else begin
            mem_we     = 1'b1;
            mem_waddr  = count_r[IW-1:0];
            cursor_nxt = count_r[IW-1:0];
            count_nxt  = count_r + 1'b1;
          end
        end else if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          case (kind_r)
            REQ_RM_IDX: begin
              if (idx_c >= cnt_c) status_nxt = ST_NOT_FOUND;
              else do_drop = 1'b1;
            end
            REQ_RM_KEY: begin
              if (hit_r) do_drop = 1'b1;
              else status_nxt = ST_NOT_FOUND;
            end
            REQ_ADVANCE: begin
              if (cursor_inc == count_r) cursor_nxt = '0;
              else cursor_nxt = cursor_r + 1'b1;
            end
            REQ_LOOKUP: begin
              if (hit_r) found_nxt = pos_r;
              else status_nxt = ST_NOT_FOUND;
            end
            default: begin
            end
          endcase
          if (do_drop) begin
            if (drop_pos < cursor_r) cursor_nxt = cursor_r - 1'b1;
            count_nxt = count_r - 1'b1;
            scan_nxt  = drop_pos;
            if ((CW'(drop_pos) + CW'(1)) < count_r) state_nxt = S_CRD;
          end
        end
      end
      S_CRD: begin
        mem_raddr = scan_r + 1'b1;
        state_nxt = S_CWR;
      end
      S_CWR: begin
        // count already holds the reduced total here
        mem_we    = 1'b1;
        mem_waddr = scan_r;
        mem_wdata = mem_rdata;
        scan_nxt  = scan_r + 1'b1;
        if (scan_inc < count_r) state_nxt = S_CRD;
        else state_nxt = S_CLAMP;
      end
      S_CLAMP: begin
        if (count_r == '0) begin
          cursor_nxt = '0;
        end else if (CW'(cursor_r) >= count_r) begin
          cursor_nxt = IW'(count_r - 1'b1);
        end
        state_nxt = S_ORD;
      end
      S_ORD: begin
        mem_raddr = cursor_r;
        state_nxt = S_OCAP;
      end
      S_OCAP: begin
        mem_raddr = cursor_r;
        res_valid = 1'b1;
        if (res_ready) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign has   = (count_r != '0);
  assign cur_w = {4'b0000, cursor_r};
  assign fnd_w = {4'b0000, found_r};
  assign cnt_w = {5'b00000, count_r};

  always_comb begin
    res.status         = status_r;
    res.has_entry      = has;
    res.cursor_index   = cur_w[3:0];
    res.entry_total    = cnt_w[4:0];
    res.cursor_key     = has ? mem_rdata[ENT_W-1:PLD_W] : '0;
    res.cursor_payload = has ? mem_rdata[PLD_W-1:0] : '0;
    res.found_index    = fnd_w[3:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      cursor_r <= '0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      cursor_r <= cursor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    key_r    <= key_nxt;
    pld_r    <= pld_nxt;
    index_r  <= index_nxt;
    scan_r   <= scan_nxt;
    pos_r    <= pos_nxt;
    hit_r    <= hit_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
  end

endmodule

>>> src/klc_checker.sv
module klc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata
);
  import klc_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one request in flight: busy right after acceptance
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready right after acceptance");

  // has_entry agrees with the entry total
  a_has: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2] == (out_tdata[11:7] != 5'd0)))
    else $error("has_entry disagrees with entry_total");

  // empty list shows cursor zero and zero data
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[2] |->
      out_tdata[6:3] == 4'd0 && out_tdata[75:12] == 64'd0)
    else $error("empty list shows nonzero cursor data");

  // empty status only reported with an empty list
  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == ST_EMPTY |-> !out_tdata[2])
    else $error("empty status with entries present");

endmodule

bind keyed_list_with_cursor_unit klc_checker u_klc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> test/tb_keyed_list_with_cursor_unit.sv
`timescale 1ns / 100ps

module tb_keyed_list_with_cursor_unit;
  import klc_pkg::*;

  localparam int LIST_DEPTH   = 16;
  localparam int KEY_POOL     = 24;   // more keys than slots, so a full list sees new keys
  localparam int RANDOM_ITEMS = 1630;
  localparam int PHASE_LEN    = 60;
  localparam int SETTLE_WAIT  = 40;
  localparam int LONG_HOLD    = 300;
  localparam int TIMEOUT_CYC  = 600000;

  // kinds the block treats like show
  localparam logic [2:0] REQ_SPARE_A = 3'd6;
  localparam logic [2:0] REQ_SPARE_B = 3'd7;

  // traffic shapes for the random part
  localparam int MIX_FILL  = 0;
  localparam int MIX_EVEN  = 1;
  localparam int MIX_DRAIN = 2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] key;
    logic [31:0] payload;
    logic [3:0]  index;
  } request_t;

  // keeps its own copy of the list and cursor, and queues the answer
  // each accepted request must produce
  class list_result_board;
    logic [31:0] key_mem [LIST_DEPTH];
    logic [31:0] payload_mem [LIST_DEPTH];
    int          entry_total;
    int          cursor_pos;
    int          errors;
    res_t        expected_results [$];

    function new();
      entry_total = 0;
      cursor_pos  = 0;
      errors      = 0;
      foreach (key_mem[i]) begin
        key_mem[i]     = '0;
        payload_mem[i] = '0;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function int find_key(logic [31:0] key);
      for (int i = 0; i < entry_total; i++) begin
        if (key_mem[i] == key) return i;
      end
      return -1;
    endfunction

    function void remove_at(int pos);
      if (pos < cursor_pos) cursor_pos--;
      for (int i = pos; i + 1 < entry_total; i++) begin
        key_mem[i]     = key_mem[i + 1];
        payload_mem[i] = payload_mem[i + 1];
      end
      entry_total--;
    endfunction

    function void note_request(request_t r);
      res_t res;
      int   pos;
      res = '0;
      res.status = ST_OK;
      if (r.kind == REQ_UPSERT) begin
        pos = find_key(r.key);
        if (pos >= 0) begin
          payload_mem[pos] = r.payload;
          cursor_pos = pos;
        end else if (entry_total >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          key_mem[entry_total]     = r.key;
          payload_mem[entry_total] = r.payload;
          cursor_pos = entry_total;
          entry_total++;
        end
      end else if (entry_total == 0) begin
        res.status = ST_EMPTY;
      end else begin
        case (r.kind)
          REQ_RM_IDX: begin
            if (int'(r.index) >= entry_total) res.status = ST_NOT_FOUND;
            else remove_at(int'(r.index));
          end
          REQ_RM_KEY: begin
            pos = find_key(r.key);
            if (pos < 0) res.status = ST_NOT_FOUND;
            else remove_at(pos);
          end
          REQ_ADVANCE: begin
            cursor_pos = (cursor_pos + 1) % entry_total;
          end
          REQ_LOOKUP: begin
            pos = find_key(r.key);
            if (pos < 0) res.status = ST_NOT_FOUND;
            else res.found_index = pos[3:0];
          end
          default: begin
          end
        endcase
      end
      // cursor never points past the last entry
      if (entry_total == 0) cursor_pos = 0;
      else if (cursor_pos >= entry_total) cursor_pos = entry_total - 1;

      res.has_entry    = (entry_total != 0);
      res.cursor_index = cursor_pos[3:0];
      res.entry_total  = entry_total[4:0];
      if (entry_total != 0) begin
        res.cursor_key     = key_mem[cursor_pos];
        res.cursor_payload = payload_mem[cursor_pos];
      end
      expected_results.insert(expected_results.size(), res);
    endfunction

    function void compare_field(string field, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic [79:0] data);
      res_t act;
      res_t exp_r;
      act = res_t'(data);
      if (expected_results.size() == 0) begin
        $display("%0t: result with no request waiting, actual %0h", $time, data);
        errors++;
        return;
      end
      exp_r = expected_results.pop_front();
      compare_field("status", 32'(exp_r.status), 32'(act.status));
      compare_field("has_entry", 32'(exp_r.has_entry), 32'(act.has_entry));
      compare_field("cursor_index", 32'(exp_r.cursor_index), 32'(act.cursor_index));
      compare_field("entry_total", 32'(exp_r.entry_total), 32'(act.entry_total));
      compare_field("cursor_key", exp_r.cursor_key, act.cursor_key);
      compare_field("cursor_payload", exp_r.cursor_payload, act.cursor_payload);
      compare_field("found_index", 32'(exp_r.found_index), 32'(act.found_index));
    endfunction
  endclass

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata   = '0;   // entry_key[31:0], entry_payload[63:32], entry_index[67:64]
  logic [2:0]  in_tuser   = '0;   // req_type[2:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;         // status, has_entry, cursor_index, entry_total,
                                  // cursor_key, cursor_payload, found_index

  list_result_board results_board = new();
  logic [31:0]      key_pool [KEY_POOL];
  bit               sender_idles;
  int               results_seen;

  keyed_list_with_cursor_unit #(
    .DEPTH(LIST_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // one request transaction; valid is only lowered when a gap follows, so a
  // back-to-back request never sees valid dropped and raised in one step
  task automatic send_request(input logic [2:0] kind, input logic [31:0] key,
                              input logic [31:0] payload, input logic [3:0] index);
    request_t r;
    int       gap;
    r   = '{kind: kind, key: key, payload: payload, index: index};
    gap = sender_idles ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, index, payload, key};
    in_tuser  <= kind;
    do @(posedge clk); while (!in_tready);
    results_board.note_request(r);
  endtask

  // mostly keys from a small pool so that hits, overwrites and a full list occur
  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 9) == 0) return $urandom();
    return key_pool[$urandom_range(0, KEY_POOL - 1)];
  endfunction

  task automatic send_random(input int mix);
    logic [2:0] kind;
    logic [3:0] index;
    int         roll;
    int         upsert_pct;
    int         remove_pct;
    upsert_pct = (mix == MIX_FILL) ? 60 : (mix == MIX_EVEN) ? 35 : 15;
    remove_pct = (mix == MIX_FILL) ? 10 : (mix == MIX_EVEN) ? 25 : 50;
    roll = $urandom_range(0, 99);
    if (roll < upsert_pct) kind = REQ_UPSERT;
    else if (roll < upsert_pct + remove_pct) kind = $urandom_range(0, 1) ? REQ_RM_IDX : REQ_RM_KEY;
    else if (roll < 97) begin
      case ($urandom_range(0, 2))
        0:       kind = REQ_ADVANCE;
        1:       kind = REQ_SHOW;
        default: kind = REQ_LOOKUP;
      endcase
    end else kind = $urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B;
    // index mostly inside the list, sometimes anywhere in its range
    if (results_board.entry_total > 0 && $urandom_range(0, 2) != 0)
      index = 4'($urandom_range(0, results_board.entry_total - 1));
    else
      index = 4'($urandom_range(0, 15));
    send_request(kind, pick_key(), $urandom(), index);
  endtask

  // result side: random stalls in stretches, one long hold to back up the input
  initial begin
    int stall;
    results_seen = 0;
    @(posedge rst_n);
    forever begin
      stall = ((results_seen / 50) % 3 != 0) ? $urandom_range(0, 14) : 0;
      if (results_seen == 400) stall = LONG_HOLD;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      results_board.check_result(out_tdata);
      results_seen++;
    end
  end

  initial begin
    int mix;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom();
    sender_idles = 1'b0;

    rst_n <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list answers
    send_request(REQ_SHOW, '0, '0, '0);
    send_request(REQ_ADVANCE, '0, '0, '0);
    send_request(REQ_LOOKUP, 32'hFFFF_FFFF, '0, '0);
    send_request(REQ_RM_IDX, '0, '0, '0);
    send_request(REQ_RM_KEY, '0, '0, '0);
    // extreme keys and payloads, then an overwrite of an existing key
    send_request(REQ_UPSERT, 32'h0000_0000, 32'h0000_0000, 4'hF);
    send_request(REQ_UPSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'h0);
    send_request(REQ_UPSERT, 32'h1234_5678, 32'hA5A5_A5A5, 4'h0);
    send_request(REQ_UPSERT, 32'h0000_0000, 32'h5A5A_5A5A, 4'h0);
    // advance around the end of the list
    send_request(REQ_ADVANCE, '0, '0, '0);
    send_request(REQ_ADVANCE, '0, '0, '0);
    send_request(REQ_ADVANCE, '0, '0, '0);
    // searches that hit and miss, index out of range, unused kinds
    send_request(REQ_LOOKUP, 32'hFFFF_FFFF, '0, '0);
    send_request(REQ_LOOKUP, 32'hDEAD_BEEF, '0, '0);
    send_request(REQ_RM_KEY, 32'hDEAD_BEEF, '0, '0);
    send_request(REQ_RM_IDX, '0, '0, 4'hF);
    send_request(REQ_SPARE_A, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
    send_request(REQ_SPARE_B, '0, '0, '0);
    // removal ahead of the cursor, removal of the last entry, back to empty
    send_request(REQ_ADVANCE, '0, '0, '0);
    send_request(REQ_RM_IDX, '0, '0, 4'h0);
    send_request(REQ_ADVANCE, '0, '0, '0);
    send_request(REQ_RM_KEY, 32'h1234_5678, '0, '0);
    send_request(REQ_RM_IDX, '0, '0, 4'h0);
    send_request(REQ_SHOW, '0, '0, '0);

    // random part in phases that fill, churn and drain the list
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % PHASE_LEN == 0) begin
        mix = (i / PHASE_LEN) % 3;
        sender_idles = (i != 0) && ($urandom_range(0, 2) != 0);
      end
      if (i == 900) begin
        // let the block drain completely before going on
        in_tvalid <= 1'b0;
        do @(posedge clk); while (results_board.pending() != 0);
      end
      send_random(mix);
    end
    in_tvalid <= 1'b0;

    while (results_board.pending() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
    if (results_board.errors == 0 && results_board.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYC * 2);
    $display("tb: failure");
    $finish;
  end

endmodule
